>>> hw/rtl/vcta_pkg.sv
// Package: widths, register indexes and pipeline types for the voxel tile address block.
`timescale 1ns / 1ps
package vcta_pkg;

    localparam int COORD_BITS = 16;
    localparam int TILE_BITS  = 8;
    localparam int TS_W       = TILE_BITS + 1;
    localparam int IN_W       = COORD_BITS + 1;
    localparam int CNT_W      = COORD_BITS + 1;
    localparam int TIP_W      = 2 * CNT_W;
    localparam int PLANE_W    = 2 * TS_W;
    localparam int DIV_STAGES = COORD_BITS;
    localparam int N_AXES     = 3;
    localparam int N_LANES    = 2 * N_AXES;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int INDEX_W    = 48;
    localparam int OFFSET_W   = 24;
    localparam int COUNT_W    = 25;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_DEPTHS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_Z   = 3'd5;

    localparam logic [TS_W-1:0] TILE_MAX = {1'b1, {TILE_BITS{1'b0}}};

    // One division lane: quotient shifts in at the bottom of num.
    typedef struct packed {
        logic [COORD_BITS-1:0] num;
        logic [TILE_BITS-1:0]  rem;
    } div_lane_t;

    // Lanes 0..2: coordinate x,y,z; lanes 3..5: region extent minus one.
    typedef struct packed {
        logic                                valid;
        logic                                ok;
        logic [N_AXES-1:0][TS_W-1:0]         tsize;
        logic [N_LANES-1:0][$bits(div_lane_t)-1:0] lane;
    } stage_t;

endpackage

>>> hw/rtl/vcta_coord_if.sv
// Interfaces: coordinate input channel and tile address output channel.
`timescale 1ns / 1ps
interface vcta_coord_if;
    import vcta_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] coord_x;
    logic signed [IN_W-1:0] coord_y;
    logic signed [IN_W-1:0] coord_z;
    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface vcta_addr_if;
    import vcta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  in_range;
    logic [INDEX_W-1:0]    tile_index;
    logic [OFFSET_W-1:0]   cell_offset;
    logic [TS_W-1:0]       tile_cols;
    logic [TS_W-1:0]       tile_rows;
    logic [TS_W-1:0]       tile_depths;
    logic [TILE_BITS-1:0]  pad_x;
    logic [TILE_BITS-1:0]  pad_y;
    logic [TILE_BITS-1:0]  pad_z;
    logic [COUNT_W-1:0]    cell_count;
    modport source (output valid, in_range, tile_index, cell_offset, tile_cols, tile_rows,
                    tile_depths, pad_x, pad_y, pad_z, cell_count, input ready);
    modport sink   (input valid, in_range, tile_index, cell_offset, tile_cols, tile_rows,
                    tile_depths, pad_x, pad_y, pad_z, cell_count, output ready);
endinterface

>>> hw/rtl/vcta_div_cell.sv
// Division cell: one restoring quotient bit for all six lanes, registered.
`timescale 1ns / 1ps
module vcta_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  vcta_pkg::stage_t stage_in,
    output vcta_pkg::stage_t stage_out
);
    import vcta_pkg::*;

    logic      valid_reg;
    stage_t    data_reg;
    stage_t    data_next;
    div_lane_t lane_cur  [N_LANES];
    div_lane_t lane_nxt  [N_LANES];
    logic [TS_W-1:0] trial [N_LANES];
    logic [TS_W-1:0] diff  [N_LANES];
    logic            ge    [N_LANES];

    always_comb
    begin
        data_next = stage_in;
        for (int l = 0; l < N_LANES; l++)
        begin
            lane_cur[l] = div_lane_t'(stage_in.lane[l]);
            trial[l] = {lane_cur[l].rem, lane_cur[l].num[COORD_BITS-1]};
            diff[l]  = trial[l] - stage_in.tsize[l % N_AXES];
            ge[l]    = trial[l] >= stage_in.tsize[l % N_AXES];
            lane_nxt[l].rem = ge[l] ? diff[l][TILE_BITS-1:0] : trial[l][TILE_BITS-1:0];
            lane_nxt[l].num = {lane_cur[l].num[COORD_BITS-2:0], ge[l]};
            data_next.lane[l] = lane_nxt[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

>>> hw/rtl/vcta_tile_calc.sv
// Tile calc: clipping, padding, then index, offset and cell count products.
`timescale 1ns / 1ps
module vcta_tile_calc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  vcta_pkg::stage_t stage_in,
    vcta_addr_if.source      addr
);
    import vcta_pkg::*;

    div_lane_t lane [N_LANES];
    logic [TS_W-1:0]      last_ext [N_AXES];
    logic [TS_W-1:0]      ext      [N_AXES];
    logic [TS_W-1:0]      pad_diff [N_AXES];

    // stage A
    logic                  a_valid_reg;
    logic                  a_ok_reg;
    logic [COORD_BITS-1:0] a_tile_reg [N_AXES];
    logic [TILE_BITS-1:0]  a_off_reg  [N_AXES];
    logic [TS_W-1:0]       a_ext_reg  [N_AXES];
    logic [TILE_BITS-1:0]  a_pad_reg  [N_AXES];
    logic [CNT_W-1:0]      a_ntx_reg;
    logic [TIP_W-1:0]      a_tip_reg;
    logic [PLANE_W-1:0]    a_plane_reg;
    logic [PLANE_W-1:0]    a_cyz_reg;
    logic [TS_W-1:0]       a_tsx_reg;
    logic [CNT_W-1:0]      ntx;
    logic [CNT_W-1:0]      nty;

    // stage B
    logic [TIP_W+COORD_BITS-1:0] idx_sum;
    logic [PLANE_W+TILE_BITS:0]  off_sum;
    logic [TS_W+PLANE_W-1:0]     cnt_prod;
    logic                  out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < N_LANES; l++)
            lane[l] = div_lane_t'(stage_in.lane[l]);
        for (int a = 0; a < N_AXES; a++)
        begin
            last_ext[a] = {1'b0, lane[a+N_AXES].rem} + TS_W'(1);
            ext[a]      = (lane[a].num == lane[a+N_AXES].num) ? last_ext[a]
                                                             : stage_in.tsize[a];
            pad_diff[a] = stage_in.tsize[a] - ext[a];
        end
        ntx = {1'b0, lane[N_AXES].num} + CNT_W'(1);
        nty = {1'b0, lane[N_AXES+1].num} + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= stage_in.valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg <= stage_in.ok;
            for (int a = 0; a < N_AXES; a++)
            begin
                a_tile_reg[a] <= lane[a].num;
                a_off_reg[a]  <= lane[a].rem;
                a_ext_reg[a]  <= ext[a];
                a_pad_reg[a]  <= pad_diff[a][TILE_BITS-1:0];
            end
            a_ntx_reg   <= ntx;
            a_tip_reg   <= ntx * nty;
            a_plane_reg <= stage_in.tsize[0] * stage_in.tsize[1];
            a_cyz_reg   <= ext[1] * ext[2];
            a_tsx_reg   <= stage_in.tsize[0];
        end
    end

    always_comb
    begin
        idx_sum  = a_tip_reg * a_tile_reg[2]
                 + a_ntx_reg * a_tile_reg[1]
                 + a_tile_reg[0];
        off_sum  = a_plane_reg * a_off_reg[2]
                 + a_tsx_reg * a_off_reg[1]
                 + a_off_reg[0];
        cnt_prod = a_ext_reg[0] * a_cyz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr.in_range    <= a_ok_reg;
            addr.tile_index  <= idx_sum[INDEX_W-1:0];
            addr.cell_offset <= off_sum[OFFSET_W-1:0];
            addr.tile_cols   <= a_ext_reg[0];
            addr.tile_rows   <= a_ext_reg[1];
            addr.tile_depths <= a_ext_reg[2];
            addr.pad_x       <= a_pad_reg[0];
            addr.pad_y       <= a_pad_reg[1];
            addr.pad_z       <= a_pad_reg[2];
            addr.cell_count  <= cnt_prod[COUNT_W-1:0];
        end
    end

    assign addr.valid = out_valid_reg;

endmodule

>>> hw/rtl/voxel_coord_to_tile_address.sv
// Top level: config registers, range check, divider cell chain and tile calc.
//
//  channel  dir  handshake       payload
//  coord    in   valid/ready     coord_x, coord_y, coord_z
//  addr     out  valid/ready     in_range, tile_index, cell_offset, extents, pads, count
//  cfg      in   cfg_we          cfg_index, cfg_data
//
// One beat per cycle while the output is not stalled; 16 divider cells (one quotient bit each)
// plus two tile calc stages, the last being the output register.
// Tile counts and clipped extents ride the same cells as region minus one.
// A stalled output freezes the whole pipeline; coord.ready = !addr.valid || addr.ready.
// Reset clears valid flags and sets all config registers to one.
`timescale 1ns / 1ps
module voxel_coord_to_tile_address (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vcta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vcta_pkg::CFG_DATA_W-1:0]   cfg_data,
    vcta_coord_if.sink                        coord,
    vcta_addr_if.source                       addr
);
    import vcta_pkg::*;

    logic [COORD_BITS-1:0] region_reg [N_AXES];
    logic [TS_W-1:0]       tsize_reg  [N_AXES];
    logic [COORD_BITS-1:0] region_fix;
    logic [TS_W-1:0]       tsize_fix;
    logic [IN_W-1:0]       coord_u    [N_AXES];
    logic                  axis_ok    [N_AXES];
    logic                  adv;
    div_lane_t             lane0      [N_LANES];
    stage_t                head;
    stage_t                pipe       [DIV_STAGES+1];

    assign region_fix = (cfg_data == '0) ? COORD_BITS'(1) : cfg_data;

    always_comb
    begin
        if (cfg_data[TS_W-1:0] == '0)
            tsize_fix = TS_W'(1);
        else if (cfg_data[TS_W-1:0] > TILE_MAX)
            tsize_fix = TILE_MAX;
        else
            tsize_fix = cfg_data[TS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                region_reg[a] <= COORD_BITS'(1);
                tsize_reg[a]  <= TS_W'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REGION_COLS:   region_reg[0] <= region_fix;
                REG_REGION_ROWS:   region_reg[1] <= region_fix;
                REG_REGION_DEPTHS: region_reg[2] <= region_fix;
                REG_TILE_SIZE_X:   tsize_reg[0]  <= tsize_fix;
                REG_TILE_SIZE_Y:   tsize_reg[1]  <= tsize_fix;
                REG_TILE_SIZE_Z:   tsize_reg[2]  <= tsize_fix;
                default:           ;
            endcase
        end
    end

    assign adv         = !addr.valid || addr.ready;
    assign coord.ready = adv;

    always_comb
    begin
        coord_u[0] = coord.coord_x;
        coord_u[1] = coord.coord_y;
        coord_u[2] = coord.coord_z;
        for (int a = 0; a < N_AXES; a++)
            axis_ok[a] = !coord_u[a][IN_W-1] && (coord_u[a][COORD_BITS-1:0] < region_reg[a]);
        head.valid = coord.valid;
        head.ok    = axis_ok[0] && axis_ok[1] && axis_ok[2];
        for (int a = 0; a < N_AXES; a++)
        begin
            head.tsize[a]       = tsize_reg[a];
            lane0[a].num        = head.ok ? coord_u[a][COORD_BITS-1:0] : '0;
            lane0[a].rem        = '0;
            lane0[a+N_AXES].num = region_reg[a] - COORD_BITS'(1);
            lane0[a+N_AXES].rem = '0;
        end
        for (int l = 0; l < N_LANES; l++)
            head.lane[l] = lane0[l];
    end

    assign pipe[0] = head;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_cell
        vcta_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .stage_in  (pipe[k]),
            .stage_out (pipe[k+1])
        );
    end

    vcta_tile_calc u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .stage_in (pipe[DIV_STAGES]),
        .addr     (addr)
    );

endmodule
